/* rtl/core/bta_pkg.sv */
// ---------------------------------------------------------------------------
// bta_pkg
// Shared types and constants of the boundary tag allocator.
// ---------------------------------------------------------------------------
package bta_pkg;

    localparam int ARENA_UNITS = 1024;
    localparam int NUNITS      = ARENA_UNITS + 2;
    localparam int AW          = $clog2(NUNITS);
    localparam int SW          = 11;
    localparam int WORD_W      = 1 + 4 * AW;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // arena entry: tag, size, prev, next, up
    typedef struct packed {
        logic          tg;
        logic [AW-1:0] sz;
        logic [AW-1:0] prv;
        logic [AW-1:0] nxt;
        logic [AW-1:0] up;
    } t_ent;

    typedef enum logic [5:0] {
        S_CLR, S_INIT, S_IDLE,
        S_A_RD, S_A_CHK,
        S_A_SP1, S_A_SP2, S_A_SP3,
        S_A_W1, S_A_W2, S_A_W3, S_A_W4, S_A_W5,
        S_F_RD0, S_F_RD1, S_F_RD2, S_F_RD3, S_F_RD4, S_F_RD5, S_F_DEC,
        S_OP_RD, S_OP_WR,
        S_OUT
    } t_state;

    localparam int OPS_MAX = 8;
    localparam int OPI_W   = $clog2(OPS_MAX + 1);

    typedef enum logic [2:0] {
        F_NONE, F_TG, F_SZ, F_PRV, F_NXT, F_UP
    } t_fld;

    // one read-modify-write of one field
    typedef struct packed {
        logic [AW-1:0] addr;
        t_fld          fld;
        logic [AW-1:0] val;
        logic          tgv;
    } t_op;

    function automatic logic [AW-1:0] ix(input logic [AW:0] a);
        return (a < (AW+1)'(NUNITS)) ? a[AW-1:0] : AW'(NUNITS - 1);
    endfunction

endpackage

/* rtl/core/bta_ram.sv */
// ---------------------------------------------------------------------------
// bta_ram
// Generic single-port synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module bta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* rtl/core/boundary_tag_allocator.sv */
// ---------------------------------------------------------------------------
// boundary_tag_allocator
// Next-fit boundary tag allocator over a unit arena held in block RAM.
// ---------------------------------------------------------------------------
// Input words carry op in tuser and req_size/free_addr in tdata; one result
// word per input word carries status, grant_addr and grant_size.
// min_split is written through i_cfg_we/i_cfg_wdata, by the user only while
// idle; the block does not enforce it. One word is processed at a time. An
// allocate walks the free list from the rover, reading and checking one free
// block in turn; the first block that fits is granted whole, or split when
// the remainder would exceed min_split, and status FULL is returned when
// nothing fits. A free updates 4 to 8 fields, each by a read then a write;
// a rejected free returns status BAD. The arena RAM port is the limit.
// After reset a clearing pass writes all NUNITS (1026) arena entries and
// then the initial free block; no input word is taken meanwhile.
// Start marks are a separate 1-bit RAM cleared in the same pass.
// The result sits in an output register until taken; while it waits no
// new input word is accepted.
// ---------------------------------------------------------------------------
module boundary_tag_allocator import bta_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // req_size[10:0], free_addr[21:11]
    input  logic        s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // grant_addr[10:0], grant_size[21:11]
    output logic [1:0]  m_axis_tuser   // status
);
    t_state r_st, n_st;
    logic [SW-1:0] r_min;
    logic [AW-1:0] r_rover, n_rover, r_cnt, n_cnt;
    logic          r_empty, n_empty;
    logic [SW-1:0] r_req, n_req;
    logic [AW-1:0] r_sp, n_sp, r_p, n_p, r_start, n_start;
    logic [AW-1:0] r_pre, n_pre, r_nx, n_nx;
    t_ent          r_e, n_e, r_es, n_es, r_en, n_en, r_ep, n_ep, r_epf, n_epf;
    logic [1:0]    r_stat, n_stat;
    logic [SW-1:0] r_ga, n_ga, r_gs, n_gs;
    t_op           r_ops [OPS_MAX];
    t_op           n_ops [OPS_MAX];
    logic [OPI_W-1:0] r_oi, n_oi, r_on, n_on;
    logic          r_mv, n_mv;

    logic          m_we;
    logic [AW-1:0] m_addr;
    t_ent          m_wd, m_rd;
    logic          k_we, k_wd, k_rd;
    logic [AW-1:0] k_addr;

    bta_ram #(.WIDTH(WORD_W), .DEPTH(NUNITS)) u_arena (
        .i_clk(i_clk), .i_we(m_we), .i_addr(m_addr), .i_wdata(m_wd), .o_rdata(m_rd)
    );
    bta_ram #(.WIDTH(1), .DEPTH(NUNITS)) u_marks (
        .i_clk(i_clk), .i_we(k_we), .i_addr(k_addr), .i_wdata(k_wd), .o_rdata(k_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_CLR;
            r_min   <= 11'd10;
            r_rover <= AW'(1);
            r_empty <= 1'b0;
            r_cnt   <= '0;
            r_mv    <= 1'b0;
            r_oi    <= '0;
            r_on    <= '0;
        end else begin
            r_st    <= n_st;
            r_min   <= i_cfg_we ? i_cfg_wdata : r_min;
            r_rover <= n_rover;
            r_empty <= n_empty;
            r_cnt   <= n_cnt;
            r_mv    <= n_mv;
            r_oi    <= n_oi;
            r_on    <= n_on;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req; r_sp <= n_sp; r_p <= n_p; r_start <= n_start;
        r_pre <= n_pre; r_nx <= n_nx; r_e <= n_e; r_es <= n_es; r_en <= n_en;
        r_ep <= n_ep; r_epf <= n_epf; r_stat <= n_stat; r_ga <= n_ga; r_gs <= n_gs;
        r_ops <= n_ops;
    end

    assign s_axis_tready = (r_st == S_IDLE) && !r_mv;
    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = {2'b00, r_gs, r_ga};
    assign m_axis_tuser  = r_stat;

    function automatic t_ent apply(input t_ent e, input t_op o);
        t_ent r;
        r = e;
        unique case (o.fld)
            F_TG:    r.tg  = o.tgv;
            F_SZ:    r.sz  = o.val;
            F_PRV:   r.prv = o.val;
            F_NXT:   r.nxt = o.val;
            F_UP:    r.up  = o.val;
            default: r = e;
        endcase
        return r;
    endfunction

    function automatic t_op mk(input logic [AW-1:0] a, input t_fld f,
                               input logic [AW-1:0] v, input logic t);
        t_op o;
        o.addr = a; o.fld = f; o.val = v; o.tgv = t;
        return o;
    endfunction

    // foot address of block at h with size s
    function automatic logic [AW-1:0] foot(input logic [AW-1:0] h,
                                           input logic [AW-1:0] s);
        return (s != '0) ? ix((AW+1)'(h) + (AW+1)'(s) - (AW+1)'(1)) : h;
    endfunction

    logic [AW:0]   w_sum;
    logic [AW-1:0] w_sz3;
    logic [AW-1:0] w_req1;

    always_comb begin
        n_st = r_st; n_rover = r_rover; n_empty = r_empty; n_cnt = r_cnt;
        n_req = r_req; n_sp = r_sp; n_p = r_p; n_start = r_start;
        n_pre = r_pre; n_nx = r_nx; n_e = r_e; n_es = r_es; n_en = r_en;
        n_ep = r_ep; n_epf = r_epf; n_stat = r_stat; n_ga = r_ga; n_gs = r_gs;
        n_ops = r_ops; n_oi = r_oi; n_on = r_on; n_mv = r_mv;
        m_we = 1'b0; m_addr = '0; m_wd = '0;
        k_we = 1'b0; k_addr = '0; k_wd = 1'b0;
        w_sum = '0; w_sz3 = '0;
        w_req1 = (r_req == '0) ? AW'(1) : AW'(r_req);
        if (m_axis_tvalid && m_axis_tready) begin
            n_mv = 1'b0;
        end
        unique case (r_st)
            S_CLR: begin
                m_we = 1'b1; m_addr = r_cnt;
                m_wd = '0;
                m_wd.tg = (r_cnt == '0) || (r_cnt == AW'(NUNITS - 1));
                k_we = 1'b1; k_addr = r_cnt; k_wd = 1'b0;
                if (r_cnt == AW'(NUNITS - 1)) begin
                    n_st = S_INIT;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            S_INIT: begin
                // head then foot of the initial block
                m_we = 1'b1;
                if (r_cnt == AW'(NUNITS - 1)) begin
                    m_addr = AW'(1);
                    m_wd.tg = 1'b0; m_wd.sz = AW'(ARENA_UNITS);
                    m_wd.prv = AW'(1); m_wd.nxt = AW'(1); m_wd.up = '0;
                    n_cnt = '0;
                end else begin
                    m_addr = AW'(ARENA_UNITS);
                    m_wd = '0; m_wd.up = AW'(1);
                    n_st = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_req = s_axis_tdata[10:0];
                    n_sp  = AW'(s_axis_tdata[21:11]);
                    n_on = '0; n_oi = '0;
                    n_stat = ST_OK; n_ga = '0; n_gs = '0;
                    if (!s_axis_tuser) begin
                        if (r_empty) begin
                            n_stat = ST_FULL; n_st = S_OUT;
                        end else begin
                            n_p = r_rover; n_start = r_rover; n_st = S_A_RD;
                        end
                    end else begin
                        if (s_axis_tdata[21:11] == '0 ||
                            s_axis_tdata[21:11] > 11'(ARENA_UNITS)) begin
                            n_stat = ST_BAD; n_st = S_OUT;
                        end else begin
                            n_st = S_F_RD0;
                        end
                    end
                end
            end
            S_A_RD: begin
                m_addr = r_p; n_st = S_A_CHK;
            end
            S_A_CHK: begin
                n_e = m_rd;
                if (m_rd.sz >= w_req1) begin
                    n_rover = ix({1'b0, m_rd.nxt});
                    n_st = S_A_SP1;
                end else if (ix({1'b0, m_rd.nxt}) != r_start) begin
                    n_p = ix({1'b0, m_rd.nxt});
                    n_st = S_A_RD;
                end else begin
                    n_stat = ST_FULL; n_st = S_OUT;
                end
            end
            S_A_SP1: begin
                if ((r_e.sz - w_req1) > AW'(r_min)) begin
                    // shrink head, new foot, granted head, granted foot
                    n_ops[0] = mk(r_p, F_SZ, r_e.sz - w_req1, 1'b0);
                    n_ops[1] = mk(foot(r_p, r_e.sz - w_req1), F_TG, '0, 1'b0);
                    n_ops[2] = mk(foot(r_p, r_e.sz - w_req1), F_UP, r_p, 1'b0);
                    n_ga = SW'(ix((AW+1)'(foot(r_p, r_e.sz - w_req1)) + (AW+1)'(1)));
                    n_gs = SW'(w_req1);
                    n_st = S_A_SP2;
                end else begin
                    n_ga = SW'(r_p); n_gs = SW'(r_e.sz);
                    n_on = '0;
                    if (ix({1'b0, r_e.nxt}) == r_p) begin
                        n_empty = 1'b1;
                    end else begin
                        n_ops[0] = mk(ix({1'b0, r_e.prv}), F_NXT, r_e.nxt, 1'b0);
                        n_ops[1] = mk(ix({1'b0, r_e.nxt}), F_PRV, r_e.prv, 1'b0);
                        n_on = OPI_W'(2);
                    end
                    n_st = S_A_W1;
                end
            end
            S_A_SP2: begin
                n_ops[3] = mk(AW'(r_ga), F_SZ, AW'(r_gs), 1'b0);
                n_ops[4] = mk(AW'(r_ga), F_TG, '0, 1'b1);
                n_st = S_A_SP3;
            end
            S_A_SP3: begin
                n_ops[5] = mk(foot(AW'(r_ga), AW'(r_gs)), F_TG, '0, 1'b1);
                n_ops[6] = mk(foot(AW'(r_ga), AW'(r_gs)), F_UP, AW'(r_ga), 1'b0);
                n_on = OPI_W'(7);
                k_we = 1'b1; k_addr = AW'(r_ga) - AW'(1); k_wd = 1'b1;
                n_oi = '0; n_st = S_OP_RD;
            end
            S_A_W1: begin
                n_ops[r_on[2:0]] = mk(r_p, F_TG, '0, 1'b1);
                n_on = r_on + OPI_W'(1);
                n_st = S_A_W2;
            end
            S_A_W2: begin
                n_ops[r_on[2:0]] = mk(foot(r_p, r_e.sz), F_TG, '0, 1'b1);
                n_ops[r_on[2:0] + 3'd1] = mk(foot(r_p, r_e.sz), F_UP, r_p, 1'b0);
                n_on = r_on + OPI_W'(2);
                k_we = 1'b1; k_addr = r_p - AW'(1); k_wd = 1'b1;
                n_oi = '0; n_st = S_OP_RD;
            end
            S_A_W3, S_A_W4, S_A_W5: begin
                n_st = S_OP_RD;
            end
            S_F_RD0: begin
                k_addr = r_sp - AW'(1); m_addr = r_sp; n_st = S_F_RD1;
            end
            S_F_RD1: begin
                n_es = m_rd;
                if (!k_rd) begin
                    n_stat = ST_BAD; n_st = S_OUT;
                end else begin
                    k_we = 1'b1; k_addr = r_sp - AW'(1); k_wd = 1'b0;
                    m_addr = r_sp - AW'(1);
                    n_st = S_F_RD2;
                end
            end
            S_F_RD2: begin
                n_epf = m_rd;
                n_pre = ix({1'b0, m_rd.up});
                n_nx = ix((AW+1)'(r_sp) + (AW+1)'(r_es.sz));
                m_addr = ix({1'b0, m_rd.up});
                n_st = S_F_RD3;
            end
            S_F_RD3: begin
                n_ep = m_rd; m_addr = r_nx; n_st = S_F_RD4;
            end
            S_F_RD4: begin
                n_en = m_rd; m_addr = r_rover; n_st = S_F_RD5;
            end
            S_F_RD5: begin
                n_e = m_rd; n_st = S_F_DEC;
            end
            S_F_DEC: begin
                n_oi = '0; n_st = S_OP_RD;
                if (r_empty) begin
                    n_ops[0] = mk(r_sp, F_PRV, r_sp, 1'b0);
                    n_ops[1] = mk(r_sp, F_NXT, r_sp, 1'b0);
                    n_ops[2] = mk(r_sp, F_TG, '0, 1'b0);
                    n_ops[3] = mk(foot(r_sp, r_es.sz), F_TG, '0, 1'b0);
                    n_ops[4] = mk(foot(r_sp, r_es.sz), F_UP, r_sp, 1'b0);
                    n_on = OPI_W'(5);
                    n_rover = r_sp; n_empty = 1'b0;
                end else if (r_epf.tg && r_en.tg) begin
                    // insert before rover
                    n_ops[0] = mk(r_sp, F_NXT, r_rover, 1'b0);
                    n_ops[1] = mk(r_sp, F_PRV, r_e.prv, 1'b0);
                    n_ops[2] = mk(r_rover, F_PRV, r_sp, 1'b0);
                    n_ops[3] = mk(ix({1'b0, r_e.prv}), F_NXT, r_sp, 1'b0);
                    n_ops[4] = mk(r_sp, F_TG, '0, 1'b0);
                    n_ops[5] = mk(foot(r_sp, r_es.sz), F_TG, '0, 1'b0);
                    n_ops[6] = mk(foot(r_sp, r_es.sz), F_UP, r_sp, 1'b0);
                    n_on = OPI_W'(7);
                    n_rover = r_sp;
                end else if (!r_epf.tg && r_en.tg) begin
                    w_sum = (AW+1)'(r_ep.sz) + (AW+1)'(r_es.sz);
                    n_ops[0] = mk(r_pre, F_SZ, w_sum[AW-1:0], 1'b0);
                    n_ops[1] = mk(r_pre, F_TG, '0, 1'b0);
                    n_ops[2] = mk(foot(r_pre, w_sum[AW-1:0]), F_TG, '0, 1'b0);
                    n_ops[3] = mk(foot(r_pre, w_sum[AW-1:0]), F_UP, r_pre, 1'b0);
                    n_on = OPI_W'(4);
                end else if (r_epf.tg && !r_en.tg) begin
                    w_sum = (AW+1)'(r_es.sz) + (AW+1)'(r_en.sz);
                    if (ix({1'b0, r_en.nxt}) == r_nx) begin
                        n_ops[0] = mk(r_sp, F_PRV, r_sp, 1'b0);
                        n_ops[1] = mk(r_sp, F_NXT, r_sp, 1'b0);
                        n_ops[2] = mk(r_sp, F_NONE, '0, 1'b0);
                        n_ops[3] = mk(r_sp, F_NONE, '0, 1'b0);
                    end else begin
                        n_ops[0] = mk(r_sp, F_PRV, r_en.prv, 1'b0);
                        n_ops[1] = mk(r_sp, F_NXT, r_en.nxt, 1'b0);
                        n_ops[2] = mk(ix({1'b0, r_en.prv}), F_NXT, r_sp, 1'b0);
                        n_ops[3] = mk(ix({1'b0, r_en.nxt}), F_PRV, r_sp, 1'b0);
                    end
                    if (r_rover == r_nx) begin
                        n_rover = r_sp;
                    end
                    n_ops[4] = mk(r_sp, F_SZ, w_sum[AW-1:0], 1'b0);
                    n_ops[5] = mk(r_sp, F_TG, '0, 1'b0);
                    n_ops[6] = mk(foot(r_sp, w_sum[AW-1:0]), F_TG, '0, 1'b0);
                    n_ops[7] = mk(foot(r_sp, w_sum[AW-1:0]), F_UP, r_sp, 1'b0);
                    n_on = OPI_W'(8);
                end else begin
                    w_sum = (AW+1)'(r_ep.sz) + (AW+1)'(r_es.sz);
                    w_sz3 = w_sum[AW-1:0] + r_en.sz;
                    n_ops[0] = mk(ix({1'b0, r_en.prv}), F_NXT, r_en.nxt, 1'b0);
                    n_ops[1] = mk(ix({1'b0, r_en.nxt}), F_PRV, r_en.prv, 1'b0);
                    n_ops[2] = mk(r_pre, F_SZ, w_sz3, 1'b0);
                    n_ops[3] = mk(r_pre, F_TG, '0, 1'b0);
                    n_ops[4] = mk(foot(r_pre, w_sz3), F_TG, '0, 1'b0);
                    n_ops[5] = mk(foot(r_pre, w_sz3), F_UP, r_pre, 1'b0);
                    n_on = OPI_W'(6);
                    if (r_rover == r_nx) begin
                        n_rover = r_pre;
                    end
                end
            end
            S_OP_RD: begin
                if (r_oi == r_on) begin
                    n_st = S_OUT;
                end else begin
                    m_addr = r_ops[r_oi[2:0]].addr;
                    n_st = S_OP_WR;
                end
            end
            S_OP_WR: begin
                m_we = r_ops[r_oi[2:0]].fld != F_NONE;
                m_addr = r_ops[r_oi[2:0]].addr;
                m_wd = apply(m_rd, r_ops[r_oi[2:0]]);
                n_oi = r_oi + OPI_W'(1);
                n_st = S_OP_RD;
            end
            S_OUT: begin
                if (!r_mv || (m_axis_tvalid && m_axis_tready)) begin
                    n_mv = 1'b1; n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end
endmodule
